// ----- rtl/dfr_pkg.sv -----
`timescale 1ns / 1ps
package dfr_pkg;

  // result kinds
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MAGIC   = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_SUM     = 2'd3;

  // header layout
  localparam logic [4:0] HDR_CMD_START = 5'd4;
  localparam logic [4:0] HDR_LEN_START = 5'd16;
  localparam logic [4:0] HDR_SUM_START = 5'd20;
  localparam logic [4:0] HDR_LAST      = 5'd23;

  // register indexes
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  localparam logic [31:0] MAXLEN_RESET = 32'd33554432;

  // block source for the compression unit
  typedef enum logic [1:0] {
    SRC_BUF,
    SRC_PAD,
    SRC_LEN,
    SRC_DIG
  } blk_src_t;

  typedef struct packed {
    logic     take;
    logic     sha_start;
    blk_src_t src;
    logic     emit_sum;
    logic     restart;
  } dfr_cmd_t;

  typedef struct packed {
    logic out_full;
    logic need_block;
    logic need_finish;
    logic rem_zero;
    logic pad_two;
    logic sha_done;
  } dfr_stat_t;

  typedef logic [31:0] word_t;

  localparam word_t SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ----- rtl/dfr_sha.sv -----
`timescale 1ns / 1ps
module dfr_sha
  import dfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t blk [16],
  input  word_t chain_in [8],
  output logic  done,
  output word_t digest [8]
);

  word_t      v [8];
  word_t      hin [8];
  word_t      w [16];
  logic [5:0] round;
  logic       busy;

  word_t s0, s1, ch, maj, t1, t2, wnew, ws0, ws1;

  // one round of the compression function
  always_comb begin
    s1   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + s1 + ch + SHA_K[round] + w[0];
    s0   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = s0 + maj;
    ws0  = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    ws1  = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wnew = ws1 + w[9] + ws0 + w[0];
  end

  // round control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= busy && (round == 6'd63);
      if (start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // working variables and message schedule
  always_ff @(posedge clk) begin
    if (start) begin
      v   <= chain_in;
      hin <= chain_in;
      w   <= blk;
    end else if (busy) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= wnew;
    end
  end

  // feed forward
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      digest[j] = hin[j] + v[j];
    end
  end

endmodule

// ----- rtl/dfr_datapath.sv -----
`timescale 1ns / 1ps
module dfr_datapath
  import dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dfr_cmd_t    cmd,
  output dfr_stat_t   stat,
  input  logic [7:0]  in_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic        is_last
);

  logic [31:0] network_magic;
  logic [31:0] max_payload_len;
  logic        phase;
  logic [4:0]  header_count;
  logic        magic_mismatch;
  logic        command_ended;
  logic [31:0] payload_remaining;
  logic [31:0] expected_checksum;
  word_t       hash_chain [8];
  word_t       block_buffer [16];
  logic [31:0] byte_count;
  logic        sum_ok;

  word_t       blk [16];
  word_t       chain_sel [8];
  word_t       digest [8];
  logic        sha_done;
  logic [5:0]  pos;
  logic [1:0]  lane;
  logic [7:0]  pb;
  logic        mm_next;
  logic [31:0] len_full;
  word_t       len_hi, len_lo;

  assign pos    = byte_count[5:0];
  assign lane   = ~pos[1:0];
  assign len_hi = {29'd0, byte_count[31:29]};
  assign len_lo = {byte_count[28:0], 3'd0};

  assign mm_next  = magic_mismatch ||
                    (in_byte != network_magic[{header_count[1:0], 3'd0} +: 8]);
  assign len_full = {in_byte, payload_remaining[23:0]};

  // status toward the controller
  always_comb begin
    stat.out_full    = out_valid;
    stat.need_block  = phase && (pos == 6'd63);
    stat.need_finish = phase ? (payload_remaining == 32'd1)
                             : ((header_count == HDR_LAST) && (payload_remaining == 32'd0));
    stat.rem_zero    = (payload_remaining == 32'd0);
    stat.pad_two     = (pos >= 6'd56);
    stat.sha_done    = sha_done;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      network_magic   <= '0;
      max_payload_len <= MAXLEN_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MAGIC:  network_magic   <= pwdata;
        REG_MAXLEN: max_payload_len <= pwdata;
        default:    network_magic   <= network_magic;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MAXLEN) ? max_payload_len : network_magic;

  // block for the compression unit
  always_comb begin
    pb = 8'h00;
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
    end
    case (cmd.src)
      SRC_BUF: begin
        blk = block_buffer;
      end
      SRC_PAD: begin
        for (int q = 0; q < 64; q++) begin
          if (6'(q) < pos) begin
            pb = block_buffer[q/4][(3 - q%4)*8 +: 8];
          end else if (6'(q) == pos) begin
            pb = 8'h80;
          end else begin
            pb = 8'h00;
          end
          blk[q/4][(3 - q%4)*8 +: 8] = pb;
        end
        if (pos < 6'd56) begin
          blk[14] = len_hi;
          blk[15] = len_lo;
        end
      end
      SRC_LEN: begin
        blk[14] = len_hi;
        blk[15] = len_lo;
      end
      SRC_DIG: begin
        for (int i = 0; i < 8; i++) begin
          blk[i] = hash_chain[i];
        end
        blk[8]  = 32'h80000000;
        blk[15] = 32'd256;
      end
      default: begin
        blk = block_buffer;
      end
    endcase
  end

  // chaining value for the compression unit
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sel[i] = (cmd.src == SRC_DIG) ? SHA_IV[i] : hash_chain[i];
    end
  end

  dfr_sha u_sha (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sha_start),
    .blk      (blk),
    .chain_in (chain_sel),
    .done     (sha_done),
    .digest   (digest)
  );

  // partial block buffer, no reset
  always_ff @(posedge clk) begin
    if (cmd.take && phase) begin
      block_buffer[pos[5:2]][{lane, 3'd0} +: 8] <= in_byte;
    end
  end

  // hash chain and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_chain <= SHA_IV;
      byte_count <= '0;
      sum_ok     <= 1'b0;
    end else begin
      if (cmd.take && !phase && (header_count == HDR_LAST)) begin
        hash_chain <= SHA_IV;
        byte_count <= '0;
      end else if (cmd.take && phase) begin
        byte_count <= byte_count + 32'd1;
      end
      if (sha_done && (cmd.src != SRC_DIG)) begin
        hash_chain <= digest;
      end
      if (sha_done && (cmd.src == SRC_DIG)) begin
        sum_ok <= (digest[0] == expected_checksum);
      end
    end
  end

  // header parser and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= 1'b0;
      header_count      <= '0;
      magic_mismatch    <= 1'b0;
      command_ended     <= 1'b0;
      payload_remaining <= '0;
      expected_checksum <= '0;
      out_valid         <= 1'b0;
      out_kind          <= KIND_CMD;
      out_byte          <= '0;
      status            <= ST_OK;
      is_last           <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit_sum) begin
        out_valid <= 1'b1;
        out_kind  <= KIND_END;
        out_byte  <= '0;
        status    <= sum_ok ? ST_OK : ST_SUM;
        is_last   <= 1'b1;
      end
      if (cmd.restart) begin
        phase          <= 1'b0;
        header_count   <= '0;
        magic_mismatch <= 1'b0;
        command_ended  <= 1'b0;
      end
      if (cmd.take) begin
        if (phase) begin
          out_valid         <= 1'b1;
          out_kind          <= KIND_PAY;
          out_byte          <= in_byte;
          status            <= ST_OK;
          is_last           <= 1'b0;
          payload_remaining <= payload_remaining - 32'd1;
        end else if (header_count < HDR_CMD_START) begin
          // magic bytes
          if ((header_count == HDR_CMD_START - 5'd1) && mm_next) begin
            out_valid      <= 1'b1;
            out_kind       <= KIND_END;
            out_byte       <= '0;
            status         <= ST_MAGIC;
            is_last        <= 1'b1;
            header_count   <= '0;
            magic_mismatch <= 1'b0;
            command_ended  <= 1'b0;
          end else begin
            magic_mismatch <= mm_next;
            header_count   <= header_count + 5'd1;
          end
        end else if (header_count < HDR_LEN_START) begin
          // command bytes up to the first zero
          if (in_byte == 8'd0) begin
            command_ended <= 1'b1;
          end else if (!command_ended) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_CMD;
            out_byte  <= in_byte;
            status    <= ST_OK;
            is_last   <= 1'b0;
          end
          header_count <= header_count + 5'd1;
        end else if (header_count < HDR_SUM_START) begin
          // little-endian length
          if (header_count == HDR_LEN_START) begin
            payload_remaining <= {24'd0, in_byte};
          end else begin
            payload_remaining[{header_count[1:0], 3'd0} +: 8] <= in_byte;
          end
          if ((header_count == HDR_SUM_START - 5'd1) && (len_full > max_payload_len)) begin
            out_valid      <= 1'b1;
            out_kind       <= KIND_END;
            out_byte       <= '0;
            status         <= ST_LEN;
            is_last        <= 1'b1;
            header_count   <= '0;
            magic_mismatch <= 1'b0;
            command_ended  <= 1'b0;
          end else begin
            header_count <= header_count + 5'd1;
          end
        end else begin
          // checksum bytes, first byte most significant
          if (header_count == HDR_SUM_START) begin
            expected_checksum <= {in_byte, 24'd0};
          end else begin
            expected_checksum[{~header_count[1:0], 3'd0} +: 8] <= in_byte;
          end
          if (header_count == HDR_LAST) begin
            header_count <= '0;
            phase        <= (payload_remaining != 32'd0);
          end else begin
            header_count <= header_count + 5'd1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/dfr_ctrl.sv -----
`timescale 1ns / 1ps
module dfr_ctrl
  import dfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dfr_stat_t stat,
  output dfr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLK_GO,
    S_BLK_WAIT,
    S_PAD_GO,
    S_PAD_WAIT,
    S_LEN_GO,
    S_LEN_WAIT,
    S_DIG_GO,
    S_DIG_WAIT,
    S_EMIT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && !stat.out_full;

  // commands and next state
  always_comb begin
    state_next    = state;
    cmd.take      = 1'b0;
    cmd.sha_start = 1'b0;
    cmd.src       = SRC_BUF;
    cmd.emit_sum  = 1'b0;
    cmd.restart   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (stat.need_block) begin
            state_next = S_BLK_GO;
          end else if (stat.need_finish) begin
            state_next = S_PAD_GO;
          end
        end
      end
      S_BLK_GO: begin
        cmd.sha_start = 1'b1;
        state_next    = S_BLK_WAIT;
      end
      S_BLK_WAIT: begin
        if (stat.sha_done) begin
          state_next = stat.rem_zero ? S_PAD_GO : S_IDLE;
        end
      end
      S_PAD_GO: begin
        cmd.src       = SRC_PAD;
        cmd.sha_start = 1'b1;
        state_next    = S_PAD_WAIT;
      end
      S_PAD_WAIT: begin
        cmd.src = SRC_PAD;
        if (stat.sha_done) begin
          state_next = stat.pad_two ? S_LEN_GO : S_DIG_GO;
        end
      end
      S_LEN_GO: begin
        cmd.src       = SRC_LEN;
        cmd.sha_start = 1'b1;
        state_next    = S_LEN_WAIT;
      end
      S_LEN_WAIT: begin
        cmd.src = SRC_LEN;
        if (stat.sha_done) begin
          state_next = S_DIG_GO;
        end
      end
      S_DIG_GO: begin
        cmd.src       = SRC_DIG;
        cmd.sha_start = 1'b1;
        state_next    = S_DIG_WAIT;
      end
      S_DIG_WAIT: begin
        cmd.src = SRC_DIG;
        if (stat.sha_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit_sum = 1'b1;
          cmd.restart  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/p2p_message_deframer_top.sv -----
`timescale 1ns / 1ps
// p2p message deframer
// input channel: one stream byte per transaction (in_valid/in_ready, in_byte)
// output channel: out_kind/out_byte/status/is_last per transaction
//   command bytes up to the first zero, then payload bytes, then one
//   end item with status (ok, bad magic, length too large, bad checksum)
// payload bytes leave before the checksum is known; drop on a bad status
// apb port: 0x0 network_magic, 0x4 max_payload_len, both readable
// output: the result of a taken byte is registered and shows in the next cycle
// input: a byte is taken only once the output register is empty, so a byte with
//   a result holds off the next until it is accepted, a header byte with none
//   does not; every 64th payload byte starts a sha-256 compression on the
//   shared round unit (one round per cycle), and no byte is taken until it ends
// message end: 2 or 3 compressions before the status item, set by the
//   payload padding and the second hash
// reset: synchronous, returns to header hunting with default registers
// receiver stall: the output register holds; no new byte is taken
module p2p_message_deframer_top
  import dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic        is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dfr_cmd_t  cmd;
  dfr_stat_t stat;

  assign pready = 1'b1;

  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_byte),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .status    (status),
    .is_last   (is_last)
  );

endmodule

// ----- rtl/dfr_checker.sv -----
`timescale 1ns / 1ps
module dfr_checker
  import dfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       is_last
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(status) && $stable(is_last))
    else $error("output changed while stalled");

  // end items close a message with a zero byte
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == KIND_END) |-> is_last && (out_byte == 8'd0))
    else $error("malformed end item");

  // data items carry no status
  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != KIND_END) |-> !is_last && (status == ST_OK))
    else $error("data item with status");

  // no unused kind code
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_CMD) || (out_kind == KIND_PAY) || (out_kind == KIND_END))
    else $error("bad kind");

endmodule

bind p2p_message_deframer_top dfr_checker u_dfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_byte  (out_byte),
  .status    (status),
  .is_last   (is_last)
);

// ----- bench/p2p_message_deframer_top_tb.sv -----
`timescale 1ns / 1ps
module p2p_message_deframer_top_tb
  import dfr_pkg::*;
;

  // expected output transaction
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] st;
    logic       last;
  } frame_item_t;

  // deframer predictor and expected-output store
  class deframe_scoreboard;
    word_t       magic;
    word_t       maxlen;
    bit          in_payload;
    int          hdr_pos;
    bit          magic_bad;
    bit          cmd_done;
    word_t       remaining;
    word_t       want_sum;
    logic [7:0]  payload[$];
    frame_item_t expected_items[$];
    int          errors;

    function new();
      magic = '0;
      maxlen = MAXLEN_RESET;
      errors = 0;
      restart();
      remaining = '0;
      want_sum = '0;
    endfunction

    function void restart();
      in_payload = 0;
      hdr_pos = 0;
      magic_bad = 0;
      cmd_done = 0;
    endfunction

    function void set_reg(logic idx, word_t val);
      if (idx == REG_MAGIC) magic = val;
      else maxlen = val;
    endfunction

    function word_t rotr(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(inout word_t h[8], input word_t blk[16]);
      word_t w[64];
      word_t a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = h[0]; b = h[1]; c = h[2]; d = h[3];
      e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int i = 0; i < 64; i++) begin
        t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + SHA_K[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    endfunction

    // first word of the double sha-256 of a byte string
    function word_t double_sha_word(logic [7:0] msg[$]);
      logic [7:0] padded[$];
      logic [63:0] bits;
      word_t h[8];
      word_t blk[16];
      padded = msg;
      bits = 64'(msg.size()) * 8;
      padded = {padded, 8'h80};
      while (padded.size() % 64 != 56) padded = {padded, 8'h00};
      for (int i = 7; i >= 0; i--) padded = {padded, bits[8*i +: 8]};
      h = SHA_IV;
      for (int base = 0; base < padded.size(); base += 64) begin
        for (int j = 0; j < 16; j++)
          blk[j] = {padded[base+4*j], padded[base+4*j+1],
                    padded[base+4*j+2], padded[base+4*j+3]};
        compress(h, blk);
      end
      for (int j = 0; j < 8; j++) blk[j] = h[j];
      blk[8] = 32'h80000000;
      for (int j = 9; j < 15; j++) blk[j] = '0;
      blk[15] = 32'd256;
      h = SHA_IV;
      compress(h, blk);
      return h[0];
    endfunction

    function void push_item(logic [1:0] kind, logic [7:0] data, logic [1:0] st);
      frame_item_t it;
      it.kind = kind;
      it.data = data;
      it.st = st;
      it.last = (kind == KIND_END);
      expected_items = {expected_items, it};
    endfunction

    function void close_message();
      push_item(KIND_END, 8'h00,
                (double_sha_word(payload) == want_sum) ? ST_OK : ST_SUM);
      restart();
    endfunction

    // accepted input byte
    function void note_byte(logic [7:0] b);
      int i;
      if (in_payload) begin
        push_item(KIND_PAY, b, ST_OK);
        payload = {payload, b};
        remaining--;
        if (remaining == 0) close_message();
        return;
      end
      i = hdr_pos;
      if (i < HDR_CMD_START) begin
        if (b != magic[8*i +: 8]) magic_bad = 1;
        if (i == HDR_CMD_START - 1 && magic_bad) begin
          push_item(KIND_END, 8'h00, ST_MAGIC);
          restart();
          return;
        end
      end else if (i < HDR_LEN_START) begin
        if (b == 0) cmd_done = 1;
        else if (!cmd_done) push_item(KIND_CMD, b, ST_OK);
      end else if (i < HDR_SUM_START) begin
        if (i == HDR_LEN_START) remaining = {24'h0, b};
        else remaining[8*(i - HDR_LEN_START) +: 8] = b;
        if (i == HDR_SUM_START - 1 && remaining > maxlen) begin
          push_item(KIND_END, 8'h00, ST_LEN);
          restart();
          return;
        end
      end else begin
        if (i == HDR_SUM_START) want_sum = {b, 24'h0};
        else want_sum[24 - 8*(i - HDR_SUM_START) +: 8] = b;
        if (i == HDR_LAST) begin
          payload.delete();
          if (remaining == 0) close_message();
          else begin
            in_payload = 1;
            hdr_pos = 0;
          end
          return;
        end
      end
      hdr_pos = (i + 1) % 32;
    endfunction

    // accepted output transaction
    function void check_result(logic [1:0] kind, logic [7:0] data, logic [1:0] st,
                               logic last);
      frame_item_t it;
      if (expected_items.size() == 0) begin
        $error("unexpected output: kind %0d byte %h status %0d last %0d",
               kind, data, st, last);
        errors++;
        return;
      end
      it = expected_items.pop_front();
      if (kind !== it.kind) begin
        $error("out_kind: expected %0d actual %0d", it.kind, kind);
        errors++;
      end
      if (data !== it.data) begin
        $error("out_byte: expected %h actual %h", it.data, data);
        errors++;
      end
      if (st !== it.st) begin
        $error("status: expected %0d actual %0d", it.st, st);
        errors++;
      end
      if (last !== it.last) begin
        $error("is_last: expected %0d actual %0d", it.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic        is_last;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  deframe_scoreboard sb = new();
  bit idle_on = 1;
  int sent = 0;
  int stall_left = 0;

  p2p_message_deframer_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_byte(in_byte);
    if (!rst && out_valid && out_ready)
      sb.check_result(out_kind, out_byte, status, is_last);
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    in_byte = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task apb_write(input logic idx, input word_t val);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = 3'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task wait_drained();
    in_valid = 0;
    while (sb.expected_items.size() != 0) @(negedge clk);
  endtask

  // idle point: drained plus time for an in-flight end-of-message hash
  task reconfigure(input word_t magic, input word_t maxlen);
    wait_drained();
    repeat (300) @(negedge clk);
    apb_write(REG_MAGIC, magic);
    apb_write(REG_MAXLEN, maxlen);
  endtask

  // one framed message; zero_at 16 means a command with no zero
  task send_message(input int plen, input bit good_sum, input bit len_err,
                    input int zero_at);
    logic [7:0] pl[$];
    logic [7:0] b;
    word_t len;
    word_t sum;
    for (int k = 0; k < 4; k++) send_byte(sb.magic[8*k +: 8]);
    for (int k = 4; k < 16; k++) begin
      b = (k < zero_at) ? 8'($urandom_range(1, 255)) : (k == zero_at) ? 8'h00
          : 8'($urandom);
      send_byte(b);
    end
    if (len_err) begin
      if ($urandom_range(0, 1)) len = sb.maxlen + 1;
      else len = sb.maxlen + 1 + ($urandom % (32'hFFFFFFFF - sb.maxlen));
    end else len = 32'(plen);
    for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
    if (len_err) return;
    for (int k = 0; k < plen; k++) pl = {pl, 8'($urandom)};
    sum = sb.double_sha_word(pl);
    if (!good_sum) sum ^= 32'h1 << $urandom_range(0, 31);
    for (int k = 3; k >= 0; k--) send_byte(sum[8*k +: 8]);
    foreach (pl[k]) send_byte(pl[k]);
  endtask

  // four magic bytes with at least one wrong
  task send_bad_magic();
    int bad;
    bad = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++)
      send_byte((k == bad || $urandom_range(0, 3) == 0) ? ~sb.magic[8*k +: 8]
                : sb.magic[8*k +: 8]);
  endtask

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int r, plen;
    repeat (5) @(negedge clk);
    rst = 0;

    // directed: bad magic, then an empty payload with a full-length command
    send_bad_magic();
    send_message(0, 1, 0, 16);

    reconfigure(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_message(1, 1, 0, 4);
    reconfigure($urandom, 0);
    send_message(0, 0, 0, 9);
    send_message(0, 0, 1, 16);

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no)
        0: reconfigure(32'h0, 32'd40);
        1: reconfigure($urandom, MAXLEN_RESET);
        2: reconfigure($urandom, 32'd130);
        3: reconfigure(32'hFFFFFFFF, 32'd8);
        4: reconfigure($urandom, 32'hFFFFFFFE);
        default: reconfigure($urandom, 32'd70);
      endcase
      if (phase_no == 5) idle_on = 0;
      while (sent < 115 * (phase_no + 1)) begin
        r = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 66);
        if (plen > sb.maxlen) plen = sb.maxlen;
        if (r < 65) send_message(plen, 1, 0, $urandom_range(4, 16));
        else if (r < 78) send_message(plen, 0, 0, $urandom_range(4, 16));
        else if (r < 88 && sb.maxlen != 32'hFFFFFFFF)
          send_message(0, 1, 1, $urandom_range(4, 16));
        else send_bad_magic();
        if (phase_no == 2 && r == 50) wait_drained();
      end
      if (phase_no == 1) wait_drained();
    end

    wait_drained();
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.expected_items.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dfr_pkg.sv
rtl/dfr_sha.sv
rtl/dfr_datapath.sv
rtl/dfr_ctrl.sv
rtl/p2p_message_deframer_top.sv
rtl/dfr_checker.sv
bench/p2p_message_deframer_top_tb.sv
